// ===== sv/jsesc_pkg.sv =====
// ----------------------------------------------------------------------------
// jsesc_pkg
// Shared types, codes and character functions of the JSON string escaper.
// ----------------------------------------------------------------------------
package jsesc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int PADDR_W     = 3;

    // Register byte addresses (bit 2 selects the register index)
    localparam logic [PADDR_W-1:0] ADDR_ESCAPE_ENABLE = 3'd0;

    // Class of one accepted word
    localparam logic [1:0] CLS_PASS    = 2'd0;
    localparam logic [1:0] CLS_PERCENT = 2'd1;
    localparam logic [1:0] CLS_UNICODE = 2'd2;

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    localparam logic [2:0] STEP_LAST_PASS    = 3'd0;
    localparam logic [2:0] STEP_LAST_PERCENT = 3'd1;
    localparam logic [2:0] STEP_LAST_UNICODE = 3'd5;

    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_stat_t;

    function automatic logic [1:0] classify(input logic [7:0] b, input logic en);
        logic [1:0] cls;
        cls = CLS_PASS;
        if (en && (b != 8'h00)) begin
            if (b == CH_PERCENT) begin
                cls = CLS_PERCENT;
            end
            else if ((b inside {CH_BSLASH, CH_QUOTE, [8'h01:8'h1F], [8'h80:8'hFF]})) begin
                cls = CLS_UNICODE;
            end
        end
        return cls;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end
        else begin
            c = CH_UPPER_A + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    function automatic logic [2:0] last_step(input logic [1:0] cls);
        logic [2:0] s;
        case (cls)
            CLS_PERCENT: s = STEP_LAST_PERCENT;
            CLS_UNICODE: s = STEP_LAST_UNICODE;
            default:     s = STEP_LAST_PASS;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] char_at(input entry_t e, input logic [2:0] step);
        logic [7:0] c;
        c = e.data;
        if (e.cls == CLS_PERCENT) begin
            c = CH_PERCENT;
        end
        else if (e.cls == CLS_UNICODE) begin
            case (step)
                3'd0:    c = CH_BSLASH;
                3'd1:    c = CH_U;
                3'd2:    c = CH_ZERO;
                3'd3:    c = CH_ZERO;
                3'd4:    c = hex_char(e.data[7:4]);
                default: c = hex_char(e.data[3:0]);
            endcase
        end
        return c;
    endfunction

endpackage

// ===== sv/jsesc_front.sv =====
// ----------------------------------------------------------------------------
// jsesc_front
// Accepts input bytes, classifies them and registers one word for the queue.
// ----------------------------------------------------------------------------
module jsesc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             escape_enable,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    output logic             push,
    output jsesc_pkg::entry_t push_entry,
    input  logic             q_ready
);

    logic              valid_reg;
    logic              valid_next;
    jsesc_pkg::entry_t entry_reg;
    logic              take;

    // Advance whenever the held word moves on or the slot is empty
    assign in_ready   = !valid_reg || q_ready;
    assign take       = in_valid && in_ready;
    assign push       = valid_reg;
    assign push_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end
        else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            entry_reg.cls  <= jsesc_pkg::classify(in_byte, escape_enable);
            entry_reg.data <= in_byte;
        end
    end

endmodule

// ===== sv/jsesc_queue.sv =====
// ----------------------------------------------------------------------------
// jsesc_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module jsesc_queue #(
    parameter int DEPTH = jsesc_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jsesc_pkg::entry_t push_entry,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output jsesc_pkg::entry_t head_entry,
    output jsesc_pkg::q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsesc_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full   = (count_reg == CNT_W'(DEPTH));
    assign stat.empty  = (count_reg == '0);
    assign push_ready  = !stat.full;
    assign head_valid  = !stat.empty;
    assign head_entry  = mem[rd_ptr_reg];
    assign do_push     = push && !stat.full;
    assign do_pop      = pop && !stat.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/jsesc_back.sv =====
// ----------------------------------------------------------------------------
// jsesc_back
// Sequencer that expands each word into its characters through an output
// register.
// ----------------------------------------------------------------------------
module jsesc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  jsesc_pkg::entry_t     head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_char,
    output logic                  run_last,
    output jsesc_pkg::back_stat_t stat
);

    logic              busy_reg;
    jsesc_pkg::entry_t ent_reg;
    logic [2:0]        step_reg;
    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              run_last_reg;

    jsesc_pkg::entry_t cur;
    logic [2:0]        cur_step;
    logic              have;
    logic              load;
    logic              emit;
    logic              is_last;

    // Work from the held word mid-run, else straight from the queue head
    assign cur      = busy_reg ? ent_reg : head_entry;
    assign cur_step = busy_reg ? step_reg : 3'd0;
    assign have     = busy_reg || head_valid;
    assign load     = !out_valid_reg || out_ready;
    assign emit     = load && have;
    assign is_last  = (cur_step == jsesc_pkg::last_step(cur.cls));
    assign pop      = emit && !busy_reg;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_last  = run_last_reg;
    assign stat.busy = busy_reg;
    assign stat.pop  = pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                out_valid_reg <= have;
            end
            if (emit) begin
                busy_reg <= !is_last;
                step_reg <= cur_step + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            ent_reg      <= cur;
            out_char_reg <= jsesc_pkg::char_at(cur, cur_step);
            run_last_reg <= is_last;
        end
    end

endmodule

// ===== sv/json_string_byte_escaper.sv =====
// ----------------------------------------------------------------------------
// json_string_byte_escaper
// Escapes a Latin-1 byte stream for use inside a JSON string literal.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready / in_byte, one byte per word.
// Output channel: out_valid / out_ready / out_char / run_last, one character
// per word; run_last marks the final character produced by an input byte.
// With escape_enable set, '%' becomes "%%", and backslash, double quote,
// 0x01-0x1F and 0x80-0xFF become \u00XX in upper-case hex; all other bytes,
// and the zero terminator always, pass through as one character.
// escape_enable is written over the APB port at address 0; pready is tied
// high and writes complete in the access cycle.
// A byte passes the front register, the queue, then the output register.
// Plain bytes go in at one input byte per cycle while the receiver keeps up;
// a percent sign gives two characters, a \u escape six. Unless stalled, the
// sequencer drives one character per cycle into its single output register.
// Reset clears the queue, the sequencer and escape_enable (escaping off).
// When the receiver stalls, the output register holds its character, the
// two-entry queue and front register fill, then in_ready drops.
// ----------------------------------------------------------------------------
module json_string_byte_escaper #(
    parameter int QUEUE_DEPTH = jsesc_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jsesc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input bytes
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_byte,
    // output characters
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_char,
    output logic                          run_last
);

    logic                  escape_enable_reg;
    logic                  cfg_write;
    logic                  sel_enable;

    logic                  push;
    jsesc_pkg::entry_t     push_entry;
    logic                  q_ready;
    logic                  pop;
    logic                  head_valid;
    jsesc_pkg::entry_t     head_entry;
    jsesc_pkg::q_stat_t    q_stat;
    jsesc_pkg::back_stat_t b_stat;

    // Register index is paddr[2]; lower bits are the byte offset
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign sel_enable = (paddr[2] == jsesc_pkg::ADDR_ESCAPE_ENABLE[2]);
    assign prdata     = sel_enable ? {31'd0, escape_enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            escape_enable_reg <= 1'b0;
        end
        else if (cfg_write && sel_enable) begin
            escape_enable_reg <= pwdata[0];
        end
    end

    // Front: accept and classify
    jsesc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .escape_enable (escape_enable_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .push          (push),
        .push_entry    (push_entry),
        .q_ready       (q_ready)
    );

    // Queue decouples the two sides
    jsesc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .stat       (q_stat)
    );

    // Back: expand each word into characters
    jsesc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .run_last   (run_last),
        .stat       (b_stat)
    );

    // A word offered to a full queue is held back: q_ready is low
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_stat.full) |-> !q_ready)
        else $error("push into full queue not held back");

    // Back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // No new word is taken mid-run
    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.busy |-> !b_stat.pop)
        else $error("queue popped during an escape run");

    // A terminator is always a single-character run
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_char == 8'h00)) |-> run_last)
        else $error("terminator without run_last");

endmodule

// ===== tb/sv/json_string_byte_escaper_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_byte_escaper_test
// Self-checking bench for the JSON string byte escaper.
// ----------------------------------------------------------------------------
// Feeds directed edge bytes, then random strings, mostly zero-terminated, to
// the byte channel. Escaping is switched on and off over the APB port. A
// scoreboard predicts the characters each byte should produce. Every
// character that leaves the block is checked in order against that
// prediction. Both channels idle at random, and the output side holds off
// long enough to back the block up.
// ----------------------------------------------------------------------------

localparam int unsigned REG_ESCAPE_ENABLE = 0;

localparam logic [7:0] CHR_NUL     = 8'h00;
localparam logic [7:0] CHR_QUOTE   = 8'h22;
localparam logic [7:0] CHR_PERCENT = 8'h25;
localparam logic [7:0] CHR_DIGIT0  = 8'h30;
localparam logic [7:0] CHR_ALPHA_A = 8'h41;
localparam logic [7:0] CHR_BSLASH  = 8'h5C;
localparam logic [7:0] CHR_LOWER_U = 8'h75;
localparam logic [7:0] CHR_CTRL_HI = 8'h1F;
localparam logic [7:0] CHR_HIGH_LO = 8'h80;

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} esc_char_t;

class json_escape_scoreboard;
    esc_char_t   pending_chars[$];
    logic        escape_en;
    int unsigned bytes_noted;
    int unsigned escaped_bytes;
    int unsigned chars_checked;
    int unsigned mismatches;

    function new();
        escape_en     = 1'b0;
        bytes_noted   = 0;
        escaped_bytes = 0;
        chars_checked = 0;
        mismatches    = 0;
    endfunction

    function void write_register(input int unsigned index, input logic [31:0] value);
        if (index == REG_ESCAPE_ENABLE) begin
            escape_en = value[0];
        end
    endfunction

    function void push_char(input logic [7:0] c, input logic last);
        esc_char_t e;
        e.ch   = c;
        e.last = last;
        pending_chars.push_back(e);
    endfunction

    function logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHR_DIGIT0 + {4'd0, nib};
        end
        return CHR_ALPHA_A + {4'd0, nib} - 8'd10;
    endfunction

    // Predict the characters produced by one accepted byte.
    function void note_byte(input logic [7:0] b);
        bytes_noted++;
        if (b == CHR_NUL || !escape_en) begin
            push_char(b, 1'b1);
        end
        else if (b == CHR_PERCENT) begin
            push_char(CHR_PERCENT, 1'b0);
            push_char(CHR_PERCENT, 1'b1);
        end
        else if (b == CHR_BSLASH || b == CHR_QUOTE || b <= CHR_CTRL_HI || b >= CHR_HIGH_LO) begin
            escaped_bytes++;
            push_char(CHR_BSLASH, 1'b0);
            push_char(CHR_LOWER_U, 1'b0);
            push_char(CHR_DIGIT0, 1'b0);
            push_char(CHR_DIGIT0, 1'b0);
            push_char(hex_digit(b[7:4]), 1'b0);
            push_char(hex_digit(b[3:0]), 1'b1);
        end
        else begin
            push_char(b, 1'b1);
        end
    endfunction

    function void check_char(input logic [7:0] c, input logic last);
        esc_char_t e;
        chars_checked++;
        if (pending_chars.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected character: expected none, actual %h run_last %b",
                     $time, c, last);
            return;
        end
        e = pending_chars.pop_front();
        if (e.ch !== c) begin
            mismatches++;
            $display("%0t: out_char mismatch: expected %h, actual %h", $time, e.ch, c);
        end
        if (e.last !== last) begin
            mismatches++;
            $display("%0t: run_last mismatch: expected %b, actual %b", $time, e.last, last);
        end
    endfunction
endclass

module json_string_byte_escaper_test;

    localparam int unsigned PW            = jsesc_pkg::PADDR_W;
    localparam logic [PW-1:0] ADDR_UNUSED = 3'd4;   // register index 1: no such register
    localparam int unsigned SETTLE_CYCLES = 6;      // drains the front, queue and output registers, plus margin
    localparam int unsigned HOLD_CYCLES   = 60;
    localparam int unsigned NO_HOLD       = 32'hFFFF_FFFF;

    // edge bytes with escaping off, then with escaping on
    localparam logic [7:0] EDGE_BYTES_OFF [5] = '{8'h00, 8'h25, 8'h5C, 8'hFF, 8'h01};
    localparam logic [7:0] EDGE_BYTES_ON [15] = '{
        8'h00, 8'h01, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h25, 8'h5C,
        8'h7E, 8'h7F, 8'h80, 8'hFF, 8'hAB, 8'h9A, 8'h41
    };

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [PW-1:0] paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [7:0]    in_byte = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [7:0]    out_char;
    logic          run_last;

    json_escape_scoreboard sb;

    int unsigned tx_idle_pct = 31;
    int unsigned rx_idle_pct = 85;
    int unsigned bytes_sent  = 0;
    bit          hold_req    = 1'b0;

    json_string_byte_escaper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .run_last  (run_last)
    );

    always #10 clk = ~clk;

    // Sample both channels at the rising edge. Noting the input before
    // checking the output keeps the order fixed within one edge.
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_byte(in_byte);
            end
            if (out_valid && out_ready)
            begin
                sb.check_char(out_char, run_last);
            end
        end
    end

    // Receiver: drop ready at random, or hold it low for a long stretch
    // on request so the queue fills and in_ready falls.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one word on the byte channel. Starts and ends at a falling
    // edge; valid stays high so back-to-back words need no gap.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            in_byte  = 8'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Text-like byte mix: anything, printable ASCII, the special
    // characters, control bytes and the upper half.
    function automatic logic [7:0] random_text_byte();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 30) return 8'($urandom_range(255));
        if (sel < 60) return 8'($urandom_range(8'h7E, 8'h20));
        if (sel < 80)
        begin
            case ($urandom_range(2))
                0:       return CHR_PERCENT;
                1:       return CHR_BSLASH;
                default: return CHR_QUOTE;
            endcase
        end
        if (sel < 90) return 8'($urandom_range(8'h1F, 8'h01));
        return 8'($urandom_range(8'hFF, 8'h80));
    endfunction

    // One string: random body, usually closed by a terminator.
    task automatic push_string();
        int unsigned len;
        len = $urandom_range(12);
        repeat (len) push_byte(random_text_byte());
        if ($urandom_range(99) < 90)
        begin
            push_byte(CHR_NUL);
        end
    endtask

    // Drop valid, wait for every predicted character, then let the
    // pipeline go quiet.
    task automatic settle_outputs();
        in_valid = 1'b0;
        while (sb.pending_chars.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_write(input logic [PW-1:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.write_register(int'(addr >> 2), data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Read escape_enable back and compare with the predicted value.
    task automatic reg_read_check();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = jsesc_pkg::ADDR_ESCAPE_ENABLE;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== {31'd0, sb.escape_en})
        begin
            sb.mismatches++;
            $display("%0t: prdata mismatch: expected %h, actual %h",
                     $time, {31'd0, sb.escape_en}, prdata);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Random strings with the given idle rates. A long output hold-off
    // starts once hold_after words of this phase went in.
    task automatic run_text_phase(input int unsigned n_bytes, input int unsigned tx_pct,
                                  input int unsigned rx_pct, input int unsigned hold_after);
        int unsigned start;
        bit          hold_done;
        start       = bytes_sent;
        hold_done   = 1'b0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (bytes_sent - start < n_bytes)
        begin
            if (!hold_done && bytes_sent - start >= hold_after)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            push_string();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Escaping is off after reset: every byte passes as is.
        reg_read_check();
        foreach (EDGE_BYTES_OFF[i]) push_byte(EDGE_BYTES_OFF[i]);
        settle_outputs();

        // Escaping on: terminator, control and high bytes, quote,
        // backslash, percent and the plain neighbors of each range.
        apb_write(jsesc_pkg::ADDR_ESCAPE_ENABLE, 32'h0000_0001);
        reg_read_check();
        foreach (EDGE_BYTES_ON[i]) push_byte(EDGE_BYTES_ON[i]);
        settle_outputs();

        // A write to an address with no register must change nothing.
        apb_write(ADDR_UNUSED, 32'h0000_0000);
        reg_read_check();
        push_byte(CHR_QUOTE);
        settle_outputs();

        // Only bit 0 counts: this value turns escaping off.
        apb_write(jsesc_pkg::ADDR_ESCAPE_ENABLE, 32'hFFFF_FFFE);
        reg_read_check();
        push_byte(CHR_BSLASH);
        settle_outputs();

        // Slow receiver, escaping on, one long hold-off mid-phase.
        apb_write(jsesc_pkg::ADDR_ESCAPE_ENABLE, 32'h8000_0001);
        reg_read_check();
        run_text_phase(130, 31, 85, 50);
        settle_outputs();

        // Slow sender, escaping off.
        apb_write(jsesc_pkg::ADDR_ESCAPE_ENABLE, 32'h0000_0000);
        reg_read_check();
        run_text_phase(100, 85, 31, NO_HOLD);
        settle_outputs();

        // Full rate both ways, escaping on; the hold-off here backs
        // the block up hard since the sender never pauses.
        apb_write(jsesc_pkg::ADDR_ESCAPE_ENABLE, 32'hFFFF_FFFF);
        reg_read_check();
        run_text_phase(170, 0, 0, 60);
        settle_outputs();
        repeat (10) @(negedge clk);

        $display("Sent %0d bytes (%0d as unicode escapes), checked %0d characters,",
                 sb.bytes_noted, sb.escaped_bytes, sb.chars_checked);
        $display("with escaping on and off, masked and unused register writes, long stalls.");
        if (sb.mismatches == 0 && sb.pending_chars.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/jsesc_pkg.sv
sv/jsesc_front.sv
sv/jsesc_queue.sv
sv/jsesc_back.sv
sv/json_string_byte_escaper.sv
tb/sv/json_string_byte_escaper_test.sv
